/* sv/mcmrb_pkg.sv */
// ----------------------------------------------------------------------------
// mcmrb_pkg
// Shared sizes, codes and types of the multi-channel mixing ring buffer.
// ----------------------------------------------------------------------------
package mcmrb_pkg;

	localparam int RING_SIZE    = 512;
	localparam int NUM_CHANNELS = 16;

	localparam int ADDR_W = $clog2(RING_SIZE);
	localparam int LEN_W  = $clog2(RING_SIZE + 1);
	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic OP_MIX  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DROPPED  = 2'd1;
	localparam logic [1:0] ST_UNDERRUN = 2'd2;

	typedef struct packed {
		logic               operation;
		logic [3:0]         channel;
		logic signed [15:0] sample_in;
	} in_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic [1:0]         status;
		logic [9:0]         buffered_length;
	} out_t;

	// One accepted item as handed from the control unit to the mix stage.
	typedef struct packed {
		logic               valid;
		logic               mem;
		logic               op;
		logic               fresh;
		logic signed [15:0] sample;
		logic [ADDR_W-1:0]  slot;
		logic [1:0]         status;
		logic [LEN_W-1:0]   fill;
	} issue_t;

endpackage

/* sv/mcmrb_ram.sv */
// ----------------------------------------------------------------------------
// mcmrb_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mcmrb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/mcmrb_ctrl.sv */
// ----------------------------------------------------------------------------
// mcmrb_ctrl
// Read head, fill length and channel offsets; decides each item's access.
// ----------------------------------------------------------------------------
module mcmrb_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  mcmrb_pkg::in_t                    cmd,
	output logic                              rd_en,
	output logic [mcmrb_pkg::ADDR_W-1:0]      rd_addr,
	output mcmrb_pkg::issue_t                 issue
);

	logic [mcmrb_pkg::ADDR_W-1:0] head_q;
	logic [mcmrb_pkg::LEN_W-1:0]  fill_q;
	logic [mcmrb_pkg::LEN_W-1:0]  offs_q [0:mcmrb_pkg::NUM_CHANNELS-1];

	logic                         in_range;
	logic [mcmrb_pkg::CH_W-1:0]   ch_idx;
	logic [mcmrb_pkg::LEN_W-1:0]  off_sel;
	logic [mcmrb_pkg::LEN_W-1:0]  off_inc;
	logic [mcmrb_pkg::LEN_W:0]    slot_sum;
	logic [mcmrb_pkg::ADDR_W-1:0] slot;
	logic [mcmrb_pkg::ADDR_W-1:0] head_next;
	logic                         do_mix;
	logic                         do_read;
	logic                         full;

	assign in_range = 32'(cmd.channel) < mcmrb_pkg::NUM_CHANNELS;
	assign ch_idx   = mcmrb_pkg::CH_W'(cmd.channel);
	assign off_sel  = offs_q[ch_idx];
	assign off_inc  = off_sel + 1'b1;
	assign full     = 32'(off_sel) == mcmrb_pkg::RING_SIZE;

	// The offset is below the ring size here, so one subtract wraps the sum.
	assign slot_sum = (mcmrb_pkg::LEN_W + 1)'(head_q) + (mcmrb_pkg::LEN_W + 1)'(off_sel);
	always_comb begin
		if (32'(slot_sum) >= mcmrb_pkg::RING_SIZE) begin
			slot = mcmrb_pkg::ADDR_W'(32'(slot_sum) - mcmrb_pkg::RING_SIZE);
		end else begin
			slot = mcmrb_pkg::ADDR_W'(slot_sum);
		end
	end

	always_comb begin
		if (32'(head_q) == mcmrb_pkg::RING_SIZE - 1) begin
			head_next = '0;
		end else begin
			head_next = head_q + 1'b1;
		end
	end

	assign do_mix  = accept && (cmd.operation == mcmrb_pkg::OP_MIX) && in_range && !full;
	assign do_read = accept && (cmd.operation == mcmrb_pkg::OP_READ) && (fill_q != '0);

	assign rd_en   = do_mix || do_read;
	assign rd_addr = do_read ? head_q : slot;

	always_comb begin
		issue.valid  = accept;
		issue.mem    = do_mix || do_read;
		issue.op     = cmd.operation;
		// An offset equal to the fill length points just past the buffered
		// window, where the slot holds silence whatever the memory says.
		issue.fresh  = off_sel == fill_q;
		issue.sample = cmd.sample_in;
		issue.slot   = rd_addr;
		issue.status = mcmrb_pkg::ST_OK;
		issue.fill   = fill_q;
		if (cmd.operation == mcmrb_pkg::OP_MIX) begin
			if (in_range && full) begin
				issue.status = mcmrb_pkg::ST_DROPPED;
			end
			if (do_mix && (off_inc > fill_q)) begin
				issue.fill = off_inc;
			end
		end else begin
			if (fill_q == '0) begin
				issue.status = mcmrb_pkg::ST_UNDERRUN;
			end else begin
				issue.fill = fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			for (int i = 0; i < mcmrb_pkg::NUM_CHANNELS; i++) begin
				offs_q[i] <= '0;
			end
		end else begin
			if (do_mix || do_read) begin
				fill_q <= issue.fill;
			end
			if (do_mix) begin
				offs_q[ch_idx] <= off_inc;
			end
			if (do_read) begin
				head_q <= head_next;
				for (int i = 0; i < mcmrb_pkg::NUM_CHANNELS; i++) begin
					if (offs_q[i] != '0) begin
						offs_q[i] <= offs_q[i] - 1'b1;
					end
				end
			end
		end
	end

endmodule

/* sv/mcmrb_mix.sv */
// ----------------------------------------------------------------------------
// mcmrb_mix
// Second stage: takes the slot read, mixes with saturation and writes back, or returns the slot for a read.
// ----------------------------------------------------------------------------
module mcmrb_mix (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mcmrb_pkg::issue_t            issue,
	input  logic [15:0]                  rd_data,
	output logic                         wr_en,
	output logic [mcmrb_pkg::ADDR_W-1:0] wr_addr,
	output logic [15:0]                  wr_data,
	output logic                         done,
	output mcmrb_pkg::out_t              rsp
);

	mcmrb_pkg::issue_t            issue_s1;
	logic                         fwd_valid_q;
	logic [mcmrb_pkg::ADDR_W-1:0] fwd_addr_q;
	logic [15:0]                  fwd_data_q;
	logic                         done_q;
	mcmrb_pkg::out_t              rsp_q;

	logic signed [15:0] cur;
	logic signed [15:0] old;
	logic signed [16:0] sum;
	logic signed [15:0] mixed;

	// The write of the item just before was not yet in memory at our read.
	assign cur = (fwd_valid_q && (fwd_addr_q == issue_s1.slot)) ? fwd_data_q : rd_data;
	assign old = issue_s1.fresh ? 16'sd0 : cur;
	assign sum = {old[15], old} + {issue_s1.sample[15], issue_s1.sample};

	always_comb begin
		if (sum[16] != sum[15]) begin
			mixed = sum[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			mixed = sum[15:0];
		end
	end

	assign wr_en   = issue_s1.valid && issue_s1.mem && (issue_s1.op == mcmrb_pkg::OP_MIX);
	assign wr_addr = issue_s1.slot;
	assign wr_data = mixed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1    <= '0;
			fwd_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			issue_s1    <= issue;
			fwd_valid_q <= wr_en;
			done_q      <= issue_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q      <= wr_addr;
		fwd_data_q      <= wr_data;
		if (issue_s1.mem && (issue_s1.op == mcmrb_pkg::OP_READ)) begin
			rsp_q.sample_out <= cur;
		end else begin
			rsp_q.sample_out <= 16'sd0;
		end
		rsp_q.status          <= issue_s1.status;
		rsp_q.buffered_length <= 10'(issue_s1.fill);
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* sv/multi_channel_mixing_ring_buffer_top.sv */
// ----------------------------------------------------------------------------
// multi_channel_mixing_ring_buffer_top
// Ring of 16-bit samples into which several speaker channels are mixed.
// ----------------------------------------------------------------------------
//
//   Channel  Ports             Direction  Handshake
//   -------  ----------------  ---------  -----------------------------------
//   command  start, busy, cmd  in         taken when start is high, busy low
//   result   done, rsp         out        valid for one cycle while done high
//
// An item is taken every cycle: busy stays low. The result of an item is set
// by the registered read of the sample memory and the output register behind
// the mix. Back-to-back items that touch the same slot see each other through
// a one-entry write forward. Reset clears the head, fill length and channel
// offsets at once; the sample memory needs no clearing pass, because a slot
// outside the buffered window always holds silence and is treated as zero
// when the window grows onto it. The receiver cannot stall, so each result is
// shown exactly once.
//
// An add item mixes its sample with signed saturation into the slot at the
// head plus its channel's offset, then bumps that offset and stretches the
// fill length to cover it. A read item pops the head slot, steps the head and
// lowers every channel offset by one, never below zero.
// ----------------------------------------------------------------------------
module multi_channel_mixing_ring_buffer_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mcmrb_pkg::in_t   cmd,
	output logic             done,
	output mcmrb_pkg::out_t  rsp
);

	logic                         accept;
	logic                         rd_en;
	logic [mcmrb_pkg::ADDR_W-1:0] rd_addr;
	logic [15:0]                  rd_data;
	logic                         wr_en;
	logic [mcmrb_pkg::ADDR_W-1:0] wr_addr;
	logic [15:0]                  wr_data;
	mcmrb_pkg::issue_t            issue;

	// Every item completes in a fixed pipeline, so the block never refuses one.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	mcmrb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (cmd),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.issue   (issue)
	);

	mcmrb_ram #(
		.WIDTH (16),
		.DEPTH (mcmrb_pkg::RING_SIZE)
	) u_ring (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	mcmrb_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (issue),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.done    (done),
		.rsp     (rsp)
	);

endmodule
